### design/filter_points_near_path_defines.svh
// Assertion macros for the path proximity filter.
`ifndef FILTER_POINTS_NEAR_PATH_DEFINES_SVH
`define FILTER_POINTS_NEAR_PATH_DEFINES_SVH

`ifndef SYNTH
`define FPNP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPNP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPNP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPNP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/fpnp_pkg.sv
// Shared constants, codes and types of the path proximity filter.
package fpnp_pkg;

	localparam int COORD_BITS      = 24;
	localparam int MAX_PATH_POINTS = 256;
	localparam int IDX_BITS        = $clog2(MAX_PATH_POINTS);
	localparam int CNT_BITS        = $clog2(MAX_PATH_POINTS + 1);
	localparam int RADIUS_BITS     = 24;
	localparam int RSQ_BITS        = 2 * RADIUS_BITS;
	localparam int DIFF_BITS       = COORD_BITS + 1;
	localparam int SQ_BITS         = 2 * DIFF_BITS;
	localparam int SUM_BITS        = SQ_BITS + 1;
	localparam int CMP_BITS        = (SUM_BITS > RSQ_BITS) ? SUM_BITS : RSQ_BITS;
	localparam int BOX_BITS        = (DIFF_BITS > RADIUS_BITS) ? DIFF_BITS : RADIUS_BITS;
	localparam int ENTRY_BITS      = 2 * COORD_BITS;

	localparam int Q_DEPTH   = 2;
	localparam int QPTR_BITS = $clog2(Q_DEPTH);
	localparam int QCNT_BITS = $clog2(Q_DEPTH + 1);

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(512);
	localparam logic [RSQ_BITS-1:0]    RSQ_RESET    = RSQ_BITS'(512 * 512);

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEST   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEST   = 2'd2
	} op_t;

	typedef struct packed {
		op_t                           op;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} cmd_t;

	typedef struct packed {
		logic                idle;
		logic                emit;
		logic [CNT_BITS-1:0] count;
	} back_stat_t;

endpackage

### design/fpnp_front.sv
// Front end: accepts items, classifies the action and queues commands for the back end.
module fpnp_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             action,
	input  logic signed [fpnp_pkg::COORD_BITS-1:0] pos_x,
	input  logic signed [fpnp_pkg::COORD_BITS-1:0] pos_y,
	input  logic signed [fpnp_pkg::COORD_BITS-1:0] pos_z,
	output logic                                   cmd_valid,
	input  logic                                   cmd_ready,
	output fpnp_pkg::cmd_t                         cmd
);

	fpnp_pkg::cmd_t                      fifo_q [fpnp_pkg::Q_DEPTH];
	logic [fpnp_pkg::QPTR_BITS-1:0]      wr_ptr_q;
	logic [fpnp_pkg::QPTR_BITS-1:0]      rd_ptr_q;
	logic [fpnp_pkg::QCNT_BITS-1:0]      cnt_q;
	fpnp_pkg::cmd_t                      cls_cmd;
	logic                                cls_keep;
	logic                                push;
	logic                                pop;

	always_comb begin
		cls_cmd.x = pos_x;
		cls_cmd.y = pos_y;
		cls_cmd.z = pos_z;
		cls_keep  = 1'b1;
		case (fpnp_pkg::action_t'(action))
			fpnp_pkg::ACT_CLEAR: begin
				cls_cmd.op = fpnp_pkg::OP_CLEAR;
			end
			fpnp_pkg::ACT_APPEND: begin
				cls_cmd.op = fpnp_pkg::OP_APPEND;
			end
			fpnp_pkg::ACT_TEST: begin
				cls_cmd.op = fpnp_pkg::OP_TEST;
			end
			default: begin
				// drop unused action
				cls_cmd.op = fpnp_pkg::OP_CLEAR;
				cls_keep   = 1'b0;
			end
		endcase
	end

	assign in_ready  = (cnt_q != fpnp_pkg::QCNT_BITS'(fpnp_pkg::Q_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready && cls_keep;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == fpnp_pkg::QPTR_BITS'(fpnp_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + fpnp_pkg::QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == fpnp_pkg::QPTR_BITS'(fpnp_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + fpnp_pkg::QPTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + fpnp_pkg::QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - fpnp_pkg::QCNT_BITS'(1);
			end
		end
	end

endmodule

### design/fpnp_back.sv
// Back end: path table, distance scan pipeline, radius register and result register.
module fpnp_back (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic [fpnp_pkg::RADIUS_BITS-1:0]         cfg_wr_data,
	input  logic                                     cmd_valid,
	output logic                                     cmd_ready,
	input  fpnp_pkg::cmd_t                           cmd,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [fpnp_pkg::COORD_BITS-1:0]   kept_x,
	output logic signed [fpnp_pkg::COORD_BITS-1:0]   kept_y,
	output logic signed [fpnp_pkg::COORD_BITS-1:0]   kept_z,
	output fpnp_pkg::back_stat_t                     stat
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	localparam int CB = fpnp_pkg::COORD_BITS;

	logic [fpnp_pkg::ENTRY_BITS-1:0]    path_mem [fpnp_pkg::MAX_PATH_POINTS];

	state_t                             state_q;
	logic [fpnp_pkg::CNT_BITS-1:0]      count_q;
	logic [fpnp_pkg::CNT_BITS-1:0]      scan_idx_q;
	logic signed [CB-1:0]               tx_q;
	logic signed [CB-1:0]               ty_q;
	logic signed [CB-1:0]               tz_q;
	logic                               hit_q;
	logic [fpnp_pkg::RADIUS_BITS-1:0]   radius_q;
	logic [fpnp_pkg::RSQ_BITS-1:0]      rsq_q;

	logic                               v_s1;
	logic [fpnp_pkg::ENTRY_BITS-1:0]    ent_s1;
	logic                               v_s2;
	logic [fpnp_pkg::DIFF_BITS-1:0]     dx_s2;
	logic [fpnp_pkg::DIFF_BITS-1:0]     dy_s2;
	logic                               box_s2;
	logic                               v_s3;
	logic [fpnp_pkg::SQ_BITS-1:0]       sqx_s3;
	logic [fpnp_pkg::SQ_BITS-1:0]       sqy_s3;
	logic                               box_s3;

	logic                               out_valid_q;
	logic signed [CB-1:0]               kx_q;
	logic signed [CB-1:0]               ky_q;
	logic signed [CB-1:0]               kz_q;

	logic                               take;
	logic                               wr_en;
	logic                               issue;
	logic                               last_issue;
	logic                               pipe_busy;
	logic                               out_free;
	logic [fpnp_pkg::IDX_BITS-1:0]      rd_addr;
	logic signed [fpnp_pkg::DIFF_BITS-1:0] diff_x;
	logic signed [fpnp_pkg::DIFF_BITS-1:0] diff_y;
	logic [fpnp_pkg::DIFF_BITS-1:0]     abs_x;
	logic [fpnp_pkg::DIFF_BITS-1:0]     abs_y;
	logic [fpnp_pkg::CMP_BITS-1:0]      sq_sum;
	logic                               near;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign take       = cmd_valid && cmd_ready;
	assign wr_en      = take && (cmd.op == fpnp_pkg::OP_APPEND) &&
		(count_q < fpnp_pkg::CNT_BITS'(fpnp_pkg::MAX_PATH_POINTS));
	assign issue      = (state_q == ST_SCAN);
	assign last_issue = (scan_idx_q == count_q - fpnp_pkg::CNT_BITS'(1));
	assign pipe_busy  = v_s1 || v_s2 || v_s3;
	assign out_free   = !out_valid_q || out_ready;
	assign rd_addr    = scan_idx_q[fpnp_pkg::IDX_BITS-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			path_mem[count_q[fpnp_pkg::IDX_BITS-1:0]] <= {cmd.x, cmd.y};
		end
		ent_s1 <= path_mem[rd_addr];
	end

	always_comb begin
		diff_x = fpnp_pkg::DIFF_BITS'($signed(ent_s1[2*CB-1:CB])) - fpnp_pkg::DIFF_BITS'(tx_q);
		diff_y = fpnp_pkg::DIFF_BITS'($signed(ent_s1[CB-1:0])) - fpnp_pkg::DIFF_BITS'(ty_q);
		abs_x  = diff_x[fpnp_pkg::DIFF_BITS-1] ? fpnp_pkg::DIFF_BITS'(-diff_x) :
			fpnp_pkg::DIFF_BITS'(diff_x);
		abs_y  = diff_y[fpnp_pkg::DIFF_BITS-1] ? fpnp_pkg::DIFF_BITS'(-diff_y) :
			fpnp_pkg::DIFF_BITS'(diff_y);
		sq_sum = fpnp_pkg::CMP_BITS'(sqx_s3) + fpnp_pkg::CMP_BITS'(sqy_s3);
		near   = v_s3 && box_s3 && (sq_sum < fpnp_pkg::CMP_BITS'(rsq_q));
	end

	always_ff @(posedge clk) begin
		dx_s2  <= abs_x;
		dy_s2  <= abs_y;
		box_s2 <= (fpnp_pkg::BOX_BITS'(abs_x) < fpnp_pkg::BOX_BITS'(radius_q)) &&
			(fpnp_pkg::BOX_BITS'(abs_y) < fpnp_pkg::BOX_BITS'(radius_q));
		sqx_s3 <= fpnp_pkg::SQ_BITS'(dx_s2) * fpnp_pkg::SQ_BITS'(dx_s2);
		sqy_s3 <= fpnp_pkg::SQ_BITS'(dy_s2) * fpnp_pkg::SQ_BITS'(dy_s2);
		box_s3 <= box_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= fpnp_pkg::RADIUS_RESET;
			rsq_q    <= fpnp_pkg::RSQ_RESET;
		end else begin
			if (cfg_wr_en) begin
				radius_q <= cfg_wr_data;
			end
			rsq_q <= fpnp_pkg::RSQ_BITS'(radius_q) * fpnp_pkg::RSQ_BITS'(radius_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd.op == fpnp_pkg::OP_TEST) begin
			tx_q <= cmd.x;
			ty_q <= cmd.y;
			tz_q <= cmd.z;
		end
		if (state_q == ST_EMIT && out_free) begin
			kx_q <= tx_q;
			ky_q <= ty_q;
			kz_q <= tz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_idx_q  <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (cmd.op)
							fpnp_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							fpnp_pkg::OP_APPEND: begin
								if (wr_en) begin
									count_q <= count_q + fpnp_pkg::CNT_BITS'(1);
								end
							end
							fpnp_pkg::OP_TEST: begin
								if (count_q != '0) begin
									scan_idx_q <= '0;
									hit_q      <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					hit_q <= hit_q || near;
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + fpnp_pkg::CNT_BITS'(1);
					end
				end
				ST_DRAIN: begin
					hit_q <= hit_q || near;
					if (!pipe_busy) begin
						state_q <= hit_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kept_x     = kx_q;
	assign kept_y     = ky_q;
	assign kept_z     = kz_q;
	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.emit  = (state_q == ST_EMIT);
	assign stat.count = count_q;

endmodule

### design/filter_points_near_path.sv
// Top level of the path proximity filter: front end, command queue and scan back end.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   action, pos_x, pos_y, pos_z
//   out      output     out_valid / out_ready kept_x, kept_y, kept_z
//   cfg      input      cfg_wr_en             cfg_wr_data (search radius)
//
// Clear and append are handled in the back end's idle state; a test scans the stored path
// points, one table read per cycle, then waits in a drain step until the pipeline is empty,
// and passes through the emit step when the point is kept.
// The front queue holds two commands and keeps accepting while the back end scans, until full.
// A kept point waits in the output register; the back end holds in its emit step
// until that register is free. Reset empties the table and sets the radius to 512.
`include "filter_points_near_path_defines.svh"

module filter_points_near_path (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [fpnp_pkg::RADIUS_BITS-1:0]       cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             action,
	input  logic signed [fpnp_pkg::COORD_BITS-1:0] pos_x,
	input  logic signed [fpnp_pkg::COORD_BITS-1:0] pos_y,
	input  logic signed [fpnp_pkg::COORD_BITS-1:0] pos_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [fpnp_pkg::COORD_BITS-1:0] kept_x,
	output logic signed [fpnp_pkg::COORD_BITS-1:0] kept_y,
	output logic signed [fpnp_pkg::COORD_BITS-1:0] kept_z
);

	logic                  cmd_valid;
	logic                  cmd_ready;
	fpnp_pkg::cmd_t        cmd;
	fpnp_pkg::back_stat_t  stat;

	fpnp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	fpnp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kept_x      (kept_x),
		.kept_y      (kept_y),
		.kept_z      (kept_z),
		.stat        (stat)
	);

	`FPNP_ASSERT(a_full_not_empty, clk, arst_n, !in_ready |-> cmd_valid, "queue full but empty")
	`FPNP_ASSERT(a_take_idle, clk, arst_n, (cmd_valid && cmd_ready) |-> stat.idle, "command taken while busy")
	`FPNP_ASSERT(a_out_from_emit, clk, arst_n, $rose(out_valid) |-> $past(stat.emit), "result without emit")
	`FPNP_ASSERT(a_count_bound, clk, arst_n, stat.count <= fpnp_pkg::CNT_BITS'(fpnp_pkg::MAX_PATH_POINTS), "path count overflow")

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the path proximity filter: directed table, random phases, radius sweeps.
module tb;
	import fpnp_pkg::*;

	localparam int SETTLE_CYCLES = 800;
	localparam int HOLD_CYCLES   = 1500;
	localparam int QUIET_LIMIT   = 12000;
	localparam int PHASE_ITEMS   = 60;
	localparam int NUM_PHASES    = 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [RADIUS_BITS-1:0] radius_t;
	typedef enum {BY_MODEL, NO_POINT, KEEP_POINT} want_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct {
		action_t act;
		coord_t  x;
		coord_t  y;
		coord_t  z;
		want_t   want;
		bit      set_r;
		radius_t r;
	} row_t;

	logic    clk         = 1'b0;
	logic    arst_n      = 1'b0;
	logic    cfg_wr_en   = 1'b0;
	radius_t cfg_wr_data = '0;
	logic    in_valid    = 1'b0;
	logic    [1:0] action = '0;
	coord_t  pos_x       = '0;
	coord_t  pos_y       = '0;
	coord_t  pos_z       = '0;
	logic    out_ready   = 1'b0;
	logic    in_ready;
	logic    out_valid;
	coord_t  kept_x;
	coord_t  kept_y;
	coord_t  kept_z;

	coord_t  path_xs [MAX_PATH_POINTS];
	coord_t  path_ys [MAX_PATH_POINTS];
	int      stored_count = 0;
	radius_t radius_now   = RADIUS_RESET;
	point_t  kept_q [$];
	row_t    rows [$];
	int      errors       = 0;
	int      quiet        = 0;
	bit      calm         = 1'b0;
	bit      hold_pending = 1'b0;

	filter_points_near_path dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kept_x     (kept_x),
		.kept_y     (kept_y),
		.kept_z     (kept_z)
	);

	always #2 clk = ~clk;

	function automatic bit near_path(coord_t px, coord_t py);
		longint dx;
		longint dy;
		longint r;
		r = radius_now;
		for (int k = 0; k < stored_count; k++) begin
			dx = path_xs[k] - px;
			dy = path_ys[k] - py;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx < r && dy < r && dx * dx + dy * dy < r * r)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit apply_command(action_t a, coord_t x, coord_t y);
		bit keep;
		keep = 1'b0;
		case (a)
			ACT_CLEAR: begin
				stored_count = 0;
			end
			ACT_APPEND: begin
				if (stored_count < MAX_PATH_POINTS) begin
					path_xs[stored_count] = x;
					path_ys[stored_count] = y;
					stored_count++;
				end
			end
			ACT_TEST: begin
				keep = near_path(x, y);
			end
			default: ;
		endcase
		return keep;
	endfunction

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t jitter(coord_t c, int span);
		int off;
		off = int'($urandom_range(0, 2 * span)) - span;
		return c + coord_t'(off);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic push_item(input action_t a, input coord_t x, input coord_t y,
			input coord_t z, input want_t w);
		int gap;
		bit keep;
		point_t pt;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= a;
		pos_x    <= x;
		pos_y    <= y;
		pos_z    <= z;
		do @(posedge clk); while (in_ready !== 1'b1);
		keep = apply_command(a, x, y);
		if (a == ACT_TEST && w != BY_MODEL)
			keep = (w == KEEP_POINT);
		if (keep) begin
			pt = '{x, y, z};
			kept_q = {kept_q, pt};
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (kept_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radius(input radius_t v);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		radius_now = v;
	endtask

	task automatic add_row(input action_t a, input coord_t x, input coord_t y, input coord_t z,
			input want_t w, input bit set_r, input radius_t r);
		row_t row;
		row = '{a, x, y, z, w, set_r, r};
		rows = {rows, row};
	endtask

	task automatic run_phase(input int n);
		int done;
		int span;
		int k;
		int pick;
		coord_t cx;
		coord_t cy;
		coord_t px;
		coord_t py;
		done = 0;
		span = (radius_now > 100000) ? 100000 : int'(radius_now) + 2;
		while (done < n) begin
			if ($urandom_range(0, 9) == 0) begin
				pick = $urandom_range(0, 3);
				push_item(action_t'(pick), rand_coord(), rand_coord(), rand_coord(), BY_MODEL);
				if (pick != ACT_NONE) done++;
			end else begin
				if ($urandom_range(0, 7) != 0) begin
					push_item(ACT_CLEAR, rand_coord(), rand_coord(), rand_coord(), BY_MODEL);
					done++;
				end
				cx = rand_coord();
				cy = rand_coord();
				repeat ($urandom_range(1, 12)) begin
					push_item(ACT_APPEND, jitter(cx, 4 * span), jitter(cy, 4 * span),
						rand_coord(), BY_MODEL);
					done++;
				end
				repeat ($urandom_range(1, 10)) begin
					if (stored_count == 0 || $urandom_range(0, 3) == 0) begin
						px = rand_coord();
						py = rand_coord();
					end else begin
						k  = $urandom_range(0, stored_count - 1);
						px = jitter(path_xs[k], span);
						py = jitter(path_ys[k], span);
					end
					push_item(ACT_TEST, px, py, rand_coord(), BY_MODEL);
					done++;
				end
			end
		end
	endtask

	task automatic fill_table();
		write_radius(radius_t'(8));
		push_item(ACT_CLEAR, '0, '0, '0, BY_MODEL);
		for (int k = 0; k < MAX_PATH_POINTS + 4; k++)
			push_item(ACT_APPEND, coord_t'(k * 16), coord_t'(-k * 16), rand_coord(), BY_MODEL);
		push_item(ACT_TEST, coord_t'(255 * 16 + 3), coord_t'(-255 * 16), rand_coord(), BY_MODEL);
		push_item(ACT_TEST, coord_t'(256 * 16), coord_t'(-256 * 16), rand_coord(), BY_MODEL);
		push_item(ACT_TEST, '0, '0, rand_coord(), BY_MODEL);
		push_item(ACT_APPEND, coord_t'(100000), coord_t'(100000), rand_coord(), BY_MODEL);
		push_item(ACT_TEST, coord_t'(100000), coord_t'(100000), rand_coord(), NO_POINT);
	endtask

	initial begin
		radius_t radii [NUM_PHASES];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(ACT_TEST,   0, 0, 0, NO_POINT, 0, 0);
		add_row(ACT_NONE,   -1, -1, -1, BY_MODEL, 0, 0);
		add_row(ACT_APPEND, 0, 0, 8388607, BY_MODEL, 0, 0);
		add_row(ACT_TEST,   511, 0, -8388608, KEEP_POINT, 0, 0);
		add_row(ACT_TEST,   512, 0, 5, NO_POINT, 0, 0);
		add_row(ACT_TEST,   -511, 0, -1, KEEP_POINT, 0, 0);
		add_row(ACT_TEST,   362, 362, 7, BY_MODEL, 0, 0);
		add_row(ACT_TEST,   363, 362, 9, BY_MODEL, 0, 0);
		add_row(ACT_CLEAR,  -8388608, 8388607, -1, BY_MODEL, 0, 0);
		add_row(ACT_TEST,   0, 0, 0, NO_POINT, 0, 0);
		add_row(ACT_APPEND, 8388607, 8388607, -8388608, BY_MODEL, 0, 0);
		add_row(ACT_APPEND, -8388608, -8388608, 8388607, BY_MODEL, 0, 0);
		add_row(ACT_TEST,   8388607, 8388607, 8388607, KEEP_POINT, 0, 0);
		add_row(ACT_TEST,   -8388608, -8388608, -1, KEEP_POINT, 0, 0);
		add_row(ACT_TEST,   0, 0, 0, NO_POINT, 0, 0);
		add_row(ACT_TEST,   8388607, -8388608, 3, NO_POINT, 0, 0);
		add_row(ACT_NONE,   8388607, 8388607, 8388607, BY_MODEL, 0, 0);
		add_row(ACT_TEST,   8388100, 8388607, 11, KEEP_POINT, 0, 0);
		add_row(ACT_TEST,   8388607, 8388607, 1, NO_POINT, 1, 0);
		add_row(ACT_TEST,   0, 0, -8388608, BY_MODEL, 1, 24'hFFFFFF);
		add_row(ACT_TEST,   -8388608, 8388607, 8388607, BY_MODEL, 0, 0);
		add_row(ACT_TEST,   -1, -1, 0, BY_MODEL, 0, 0);

		foreach (rows[i]) begin
			if (rows[i].set_r)
				write_radius(rows[i].r);
			push_item(rows[i].act, rows[i].x, rows[i].y, rows[i].z, rows[i].want);
		end

		radii = '{24'd512, 24'd1, 24'd0, 24'hFFFFFF, 24'd300, 24'd4096, 24'd0, 24'd0};
		radii[6] = radius_t'($urandom);
		radii[7] = radius_t'($urandom_range(2, 2000));
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_radius(radii[p]);
			calm = (p == 4 || p == 6);
			if (p == 3)
				hold_pending = 1'b1;
			run_phase(PHASE_ITEMS);
		end
		calm = 1'b0;
		fill_table();
		settle();

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		int gap;
		point_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = calm ? 0 : $urandom_range(0, 5);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (kept_q.size() == 0) begin
				report_mismatch($sformatf("unexpected kept point (%0d, %0d, %0d)",
					kept_x, kept_y, kept_z));
			end else begin
				want = kept_q.pop_front();
				if (kept_x !== want.x)
					report_mismatch($sformatf("kept_x got %0d want %0d", kept_x, want.x));
				if (kept_y !== want.y)
					report_mismatch($sformatf("kept_y got %0d want %0d", kept_y, want.y));
				if (kept_z !== want.z)
					report_mismatch($sformatf("kept_z got %0d want %0d", kept_z, want.z));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end
endmodule
